// ----- rtl/rps_lattice_interaction_step_assert.svh -----
// ----------------------------------------------------------------------------
// Assertion macros for the rock-paper-scissors lattice block
// Concurrent assertion wrappers. They compile to nothing when NO_ASSERTIONS is set.
// ----------------------------------------------------------------------------
`ifndef RPS_LATTICE_INTERACTION_STEP_ASSERT_SVH
`define RPS_LATTICE_INTERACTION_STEP_ASSERT_SVH

`ifndef NO_ASSERTIONS

`define RPSL_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

`define RPSL_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`else

`define RPSL_ASSERT_IMP(lbl, ante, cons, msg)

`define RPSL_ASSERT_NXT(lbl, ante, cons, msg)

`endif

`endif

// ----- rtl/rpsl_pkg.sv -----
// ----------------------------------------------------------------------------
// rpsl_pkg
// Shared constants, codes and interface types of the lattice interaction block.
// ----------------------------------------------------------------------------
package rpsl_pkg;

  // Both grid sizes are powers of two, so a site address is {row, column}.
  localparam int GRID_WIDTH  = 128;
  localparam int GRID_HEIGHT = 128;
  localparam int X_W         = $clog2(GRID_WIDTH);
  localparam int Y_W         = $clog2(GRID_HEIGHT);
  localparam int ADDR_W      = X_W + Y_W;
  localparam int CELLS       = GRID_WIDTH * GRID_HEIGHT;
  localparam int CLASS_COUNT = 4;

  localparam int COUNT_W = 15;
  localparam int PROB_W  = 16;
  localparam int ROW_W   = 3 * PROB_W;

  localparam int PADDR_W   = 6;
  localparam int PDATA_W   = 64;
  localparam int REG_IDX_W = 3;

  typedef logic [1:0]         cell_t;
  typedef logic [PROB_W-1:0]  prob_t;
  typedef logic [COUNT_W-1:0] count_t;

  localparam cell_t CELL_EMPTY = 2'd0;
  localparam cell_t CELL_SP1   = 2'd1;
  localparam cell_t CELL_SP2   = 2'd2;
  localparam cell_t CELL_SP3   = 2'd3;

  localparam logic KIND_WRITE    = 1'b0;
  localparam logic KIND_INTERACT = 1'b1;

  localparam logic [1:0] DIR_Y_UP   = 2'd0;
  localparam logic [1:0] DIR_Y_DOWN = 2'd1;
  localparam logic [1:0] DIR_X_UP   = 2'd2;
  localparam logic [1:0] DIR_X_DOWN = 2'd3;

  localparam logic [1:0] EV_NONE  = 2'd0;
  localparam logic [1:0] EV_SWAP  = 2'd1;
  localparam logic [1:0] EV_PRED  = 2'd2;
  localparam logic [1:0] EV_REPRO = 2'd3;

  localparam logic [REG_IDX_W-1:0] REG_MOBILITY  = 3'd0;
  localparam logic [REG_IDX_W-1:0] REG_PRED_LIM  = 3'd1;
  localparam logic [REG_IDX_W-1:0] REG_ROW_A     = 3'd2;
  localparam logic [REG_IDX_W-1:0] REG_ROW_B     = 3'd3;
  localparam logic [REG_IDX_W-1:0] REG_ROW_C     = 3'd4;

  localparam prob_t PRED_LIM_RESET = 16'h8000;

  typedef struct packed {
    prob_t             mobility;
    prob_t             pred_limit;
    logic [ROW_W-1:0]  row_a;
    logic [ROW_W-1:0]  row_b;
    logic [ROW_W-1:0]  row_c;
  } rpsl_cfg_t;

  typedef struct packed {
    logic clear_wr;
    logic accept;
    logic commit;
    logic swap_wr;
  } rpsl_cmd_t;

  typedef struct packed {
    logic clear_last;
    logic out_free;
    logic swap_req;
  } rpsl_sts_t;

endpackage

// ----- rtl/rpsl_cfg.sv -----
// ----------------------------------------------------------------------------
// rpsl_cfg
// Register bank behind the APB-style configuration port.
// ----------------------------------------------------------------------------
module rpsl_cfg import rpsl_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [PDATA_W-1:0] pwdata,
  output logic [PDATA_W-1:0] prdata,
  output logic               pready,
  output rpsl_cfg_t          cfg
);

  rpsl_cfg_t                cfg_r;
  logic [REG_IDX_W-1:0]     reg_idx;
  logic                     wr_en;

  assign reg_idx = paddr[PADDR_W-1:3];
  assign wr_en   = psel && penable && pwrite;
  assign pready  = 1'b1;
  assign cfg     = cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.mobility   <= '0;
      cfg_r.pred_limit <= PRED_LIM_RESET;
      cfg_r.row_a      <= '0;
      cfg_r.row_b      <= '0;
      cfg_r.row_c      <= '0;
    end else if (wr_en) begin
      unique case (reg_idx)
        REG_MOBILITY: cfg_r.mobility   <= pwdata[PROB_W-1:0];
        REG_PRED_LIM: cfg_r.pred_limit <= pwdata[PROB_W-1:0];
        REG_ROW_A:    cfg_r.row_a      <= pwdata[ROW_W-1:0];
        REG_ROW_B:    cfg_r.row_b      <= pwdata[ROW_W-1:0];
        REG_ROW_C:    cfg_r.row_c      <= pwdata[ROW_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_MOBILITY: prdata = PDATA_W'(cfg_r.mobility);
      REG_PRED_LIM: prdata = PDATA_W'(cfg_r.pred_limit);
      REG_ROW_A:    prdata = PDATA_W'(cfg_r.row_a);
      REG_ROW_B:    prdata = PDATA_W'(cfg_r.row_b);
      REG_ROW_C:    prdata = PDATA_W'(cfg_r.row_c);
      default:      prdata = '0;
    endcase
  end

endmodule

// ----- rtl/rpsl_ctrl.sv -----
// ----------------------------------------------------------------------------
// rpsl_ctrl
// Sequencer: lattice clearing pass, accept, commit and second swap write.
// ----------------------------------------------------------------------------
module rpsl_ctrl import rpsl_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  input  rpsl_sts_t sts,
  output rpsl_cmd_t cmd
);

  localparam logic [1:0] ST_CLEAR = 2'd0;
  localparam logic [1:0] ST_IDLE  = 2'd1;
  localparam logic [1:0] ST_EXEC  = 2'd2;
  localparam logic [1:0] ST_SWAP  = 2'd3;

  logic [1:0] state_r;
  logic [1:0] state_nxt;

  assign in_ready = (state_r == ST_IDLE);

  always_comb begin
    state_nxt    = state_r;
    cmd          = '0;
    unique case (state_r)
      ST_CLEAR: begin
        cmd.clear_wr = 1'b1;
        if (sts.clear_last) state_nxt = ST_IDLE;
      end
      ST_IDLE: begin
        if (in_valid) begin
          cmd.accept = 1'b1;
          state_nxt  = ST_EXEC;
        end
      end
      ST_EXEC: begin
        if (sts.out_free) begin
          cmd.commit = 1'b1;
          state_nxt  = sts.swap_req ? ST_SWAP : ST_IDLE;
        end
      end
      ST_SWAP: begin
        cmd.swap_wr = 1'b1;
        state_nxt   = ST_IDLE;
      end
      default: state_nxt = ST_CLEAR;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

// ----- rtl/rpsl_datapath.sv -----
// ----------------------------------------------------------------------------
// rpsl_datapath
// Lattice memory, item registers, event decode, population counts and output.
// ----------------------------------------------------------------------------
`include "rps_lattice_interaction_step_assert.svh"

module rpsl_datapath import rpsl_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_kind,
  input  logic [X_W-1:0]   in_x_pos,
  input  logic [Y_W-1:0]   in_y_pos,
  input  cell_t            in_cell_value,
  input  logic [1:0]       in_direction,
  input  prob_t            in_action_draw,
  input  prob_t            in_predation_draw,
  input  rpsl_cfg_t        cfg,
  input  rpsl_cmd_t        cmd,
  output rpsl_sts_t        sts,
  output logic             out_valid,
  input  logic             out_ready,
  output logic [1:0]       out_event_res,
  output count_t           out_count_empty,
  output count_t           out_count_first,
  output count_t           out_count_second,
  output count_t           out_count_third,
  output logic             out_extinct
);

  cell_t               lat_mem [CELLS];

  logic [ADDR_W-1:0]   clr_cnt_r;
  logic                kind_r;
  cell_t               val_r;
  prob_t               act_r;
  prob_t               pdraw_r;
  logic [ADDR_W-1:0]   ac_r;
  logic [ADDR_W-1:0]   ps_r;
  cell_t               me_r;
  cell_t               nb_r;
  logic [1:0]          ev_r;
  logic                out_valid_r;
  count_t              cnt_r   [CLASS_COUNT];
  count_t              cnt_nxt [CLASS_COUNT];

  logic [X_W-1:0]      nx;
  logic [Y_W-1:0]      ny;
  logic [ADDR_W-1:0]   ac_in;
  logic [ADDR_W-1:0]   ps_in;

  logic [ROW_W-1:0]    row_sel;
  prob_t               kill_p;
  logic [1:0]          ev_nxt;
  logic                ex_we;
  logic [ADDR_W-1:0]   ex_wa;
  cell_t               ex_wd;
  logic                inc_en;
  cell_t               inc_cls;
  logic                dec_en;
  cell_t               dec_cls;
  logic                swap_req;

  logic                mem_we;
  logic [ADDR_W-1:0]   mem_wa;
  cell_t               mem_wd;

  // Neighbor site on the torus.
  always_comb begin
    nx = in_x_pos;
    ny = in_y_pos;
    unique case (in_direction)
      DIR_Y_UP:   ny = (in_y_pos == Y_W'(GRID_HEIGHT - 1)) ? '0 : in_y_pos + Y_W'(1);
      DIR_Y_DOWN: ny = (in_y_pos == '0) ? Y_W'(GRID_HEIGHT - 1) : in_y_pos - Y_W'(1);
      DIR_X_UP:   nx = (in_x_pos == X_W'(GRID_WIDTH - 1)) ? '0 : in_x_pos + X_W'(1);
      DIR_X_DOWN: nx = (in_x_pos == '0) ? X_W'(GRID_WIDTH - 1) : in_x_pos - X_W'(1);
      default: ;
    endcase
  end

  assign ac_in = {in_y_pos, in_x_pos};
  assign ps_in = {ny, nx};

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      kind_r  <= in_kind;
      val_r   <= in_cell_value;
      act_r   <= in_action_draw;
      pdraw_r <= in_predation_draw;
      ac_r    <= ac_in;
      ps_r    <= ps_in;
    end
  end

  // Lattice memory: two read ports used at accept, one write port.
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      me_r <= lat_mem[ac_in];
      nb_r <= lat_mem[ps_in];
    end
    if (mem_we) begin
      lat_mem[mem_wa] <= mem_wd;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_cnt_r <= '0;
    end else if (cmd.clear_wr) begin
      clr_cnt_r <= clr_cnt_r + ADDR_W'(1);
    end
  end

  always_comb begin
    unique case (me_r)
      CELL_SP1: row_sel = cfg.row_a;
      CELL_SP2: row_sel = cfg.row_b;
      default:  row_sel = cfg.row_c;
    endcase
    unique case (nb_r)
      CELL_SP1: kill_p = row_sel[PROB_W-1:0];
      CELL_SP2: kill_p = row_sel[2*PROB_W-1:PROB_W];
      default:  kill_p = row_sel[3*PROB_W-1:2*PROB_W];
    endcase
  end

  always_comb begin
    ev_nxt   = EV_NONE;
    ex_we    = 1'b0;
    ex_wa    = ac_r;
    ex_wd    = val_r;
    inc_en   = 1'b0;
    inc_cls  = CELL_EMPTY;
    dec_en   = 1'b0;
    dec_cls  = CELL_EMPTY;
    swap_req = 1'b0;
    if (kind_r == KIND_WRITE) begin
      ex_we   = 1'b1;
      inc_en  = 1'b1;
      inc_cls = val_r;
      dec_en  = 1'b1;
      dec_cls = me_r;
    end else if (me_r != CELL_EMPTY) begin
      if (act_r < cfg.mobility) begin
        ev_nxt   = EV_SWAP;
        ex_we    = 1'b1;
        ex_wd    = nb_r;
        swap_req = 1'b1;
      end else if (act_r > cfg.mobility && act_r < cfg.pred_limit) begin
        if (nb_r != CELL_EMPTY && pdraw_r < kill_p) begin
          ev_nxt  = EV_PRED;
          ex_we   = 1'b1;
          ex_wa   = ps_r;
          ex_wd   = CELL_EMPTY;
          inc_en  = 1'b1;
          dec_en  = 1'b1;
          dec_cls = nb_r;
        end
      end else if (nb_r == CELL_EMPTY) begin
        ev_nxt  = EV_REPRO;
        ex_we   = 1'b1;
        ex_wa   = ps_r;
        ex_wd   = me_r;
        inc_en  = 1'b1;
        inc_cls = me_r;
        dec_en  = 1'b1;
      end
    end
  end

  always_comb begin
    mem_we = 1'b0;
    mem_wa = ps_r;
    mem_wd = me_r;
    priority if (cmd.clear_wr) begin
      mem_we = 1'b1;
      mem_wa = clr_cnt_r;
      mem_wd = CELL_EMPTY;
    end else if (cmd.commit) begin
      mem_we = ex_we;
      mem_wa = ex_wa;
      mem_wd = ex_wd;
    end else if (cmd.swap_wr) begin
      mem_we = 1'b1;
    end
  end

  always_comb begin
    for (int c = 0; c < CLASS_COUNT; c++) begin
      logic hit_inc;
      logic hit_dec;
      hit_inc = inc_en && (inc_cls == cell_t'(c));
      hit_dec = dec_en && (dec_cls == cell_t'(c));
      cnt_nxt[c] = cnt_r[c];
      if (hit_inc && !hit_dec) cnt_nxt[c] = cnt_r[c] + COUNT_W'(1);
      if (hit_dec && !hit_inc) cnt_nxt[c] = cnt_r[c] - COUNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r[0] <= COUNT_W'(CELLS);
      for (int c = 1; c < CLASS_COUNT; c++) begin
        cnt_r[c] <= '0;
      end
    end else if (cmd.commit) begin
      for (int c = 0; c < CLASS_COUNT; c++) begin
        cnt_r[c] <= cnt_nxt[c];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      ev_r <= ev_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.commit) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  assign sts.clear_last = &clr_cnt_r;
  assign sts.out_free   = !out_valid_r || out_ready;
  assign sts.swap_req   = swap_req;

  assign out_valid        = out_valid_r;
  assign out_event_res    = ev_r;
  assign out_count_empty  = cnt_r[0];
  assign out_count_first  = cnt_r[1];
  assign out_count_second = cnt_r[2];
  assign out_count_third  = cnt_r[3];
  assign out_extinct      = (cnt_r[1] == '0) || (cnt_r[2] == '0) || (cnt_r[3] == '0);

  `RPSL_ASSERT_IMP(a_count_sum, 1'b1, COUNT_W'(cnt_r[0] + cnt_r[1] + cnt_r[2] + cnt_r[3]) == COUNT_W'(CELLS), "population counts do not add up to the lattice size")
  `RPSL_ASSERT_NXT(a_count_hold, out_valid_r && !out_ready, $stable(cnt_r[0]) && $stable(cnt_r[3]), "counts changed while a result was pending")
  `RPSL_ASSERT_NXT(a_commit_valid, cmd.commit, out_valid_r, "committed transaction did not raise out_valid")
  `RPSL_ASSERT_IMP(a_no_commit_clear, cmd.clear_wr, !cmd.commit && !cmd.accept, "item handled during the clearing pass")

endmodule

// ----- rtl/rps_lattice_interaction_step.sv -----
// ----------------------------------------------------------------------------
// rps_lattice_interaction_step
// Rock-paper-scissors lattice with population counts, one result per item.
// ----------------------------------------------------------------------------
// After reset the block clears the lattice memory, one cell per cycle, with
// in_ready low; configuration writes are taken meanwhile. A write or
// interaction transaction reads the chosen site and its neighbor through the
// two read ports of the memory in the accepting cycle; the commit, which waits
// while a result is pending on the output, writes back and updates the counts.
// A swap needs an extra write state, because the memory has one write port and
// both cells change. A new transaction is accepted while the previous result
// waits on the output, and the result of the next one is held back until taken.
module rps_lattice_interaction_step import rpsl_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic               in_kind,
  input  logic [X_W-1:0]     in_x_pos,
  input  logic [Y_W-1:0]     in_y_pos,
  input  logic [1:0]         in_cell_value,
  input  logic [1:0]         in_direction,
  input  logic [PROB_W-1:0]  in_action_draw,
  input  logic [PROB_W-1:0]  in_predation_draw,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [1:0]         out_event_res,
  output logic [COUNT_W-1:0] out_count_empty,
  output logic [COUNT_W-1:0] out_count_first,
  output logic [COUNT_W-1:0] out_count_second,
  output logic [COUNT_W-1:0] out_count_third,
  output logic               out_extinct,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [PDATA_W-1:0] pwdata,
  output logic [PDATA_W-1:0] prdata,
  output logic               pready
);

  rpsl_cfg_t cfg;
  rpsl_cmd_t cmd;
  rpsl_sts_t sts;

  rpsl_cfg u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  rpsl_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  rpsl_datapath u_dp (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_kind           (in_kind),
    .in_x_pos          (in_x_pos),
    .in_y_pos          (in_y_pos),
    .in_cell_value     (in_cell_value),
    .in_direction      (in_direction),
    .in_action_draw    (in_action_draw),
    .in_predation_draw (in_predation_draw),
    .cfg               (cfg),
    .cmd               (cmd),
    .sts               (sts),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_event_res     (out_event_res),
    .out_count_empty   (out_count_empty),
    .out_count_first   (out_count_first),
    .out_count_second  (out_count_second),
    .out_count_third   (out_count_third),
    .out_extinct       (out_extinct)
  );

endmodule
